### rtl/core/rmj_pkg.sv
package rmj_pkg;

  localparam int FRAC_BITS = 16;

  localparam int W_ITEM = 32;
  localparam int W_SQR  = 2 * W_ITEM;
  localparam int W_CUBE = 3 * W_ITEM;
  localparam int W_DEN  = W_CUBE;
  localparam int W_NUM  = W_CUBE + FRAC_BITS;
  localparam int W_OVC  = W_DEN + W_ITEM;
  localparam int W_SQREM = W_ITEM + 2;
  localparam int N_LANE = 6;
  localparam int W_LIM  = 16;
  localparam int W_ADDR = 3;

  localparam logic [W_ADDR-1:0] REG_NEAR_ZERO_LIMIT = 3'd0;
  localparam logic [W_LIM-1:0]  LIMIT_RESET         = 16'd7;

  localparam logic [W_ITEM-1:0] CAP_POS = 32'h7FFF_FFFF;
  localparam logic [W_ITEM-1:0] CAP_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [W_ITEM-1:0] mx;
    logic [W_ITEM-1:0] my;
    logic              negx;
    logic              negy;
    logic              pypos;
    logic              cneg;
    logic [W_SQR-1:0]  r2;
    logic [W_CUBE-1:0] prodx;
    logic [W_CUBE-1:0] prody;
    logic              deg;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [W_SQREM-1:0] rem;
    logic [W_ITEM-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic              neg;
    logic              over;
    logic [W_ITEM-1:0] nlo;
    logic [W_DEN-1:0]  den;
    logic [W_DEN-1:0]  rem;
    logic [W_ITEM-1:0] q;
  } lane_t;

  typedef struct packed {
    logic              deg;
    lane_t [N_LANE-1:0] ln;
  } dv_t;

endpackage

### rtl/core/radar_measurement_jacobian.sv
// Radar measurement Jacobian for an extended Kalman filter, one state per cycle.
// The input stream carries a state vector (pos_x, pos_y, vel_x, vel_y) in signed
// Q16.16 fixed point; each transaction yields exactly one result transaction with
// the six distinct Jacobian entries and a degenerate flag in tuser.
// The APB-style port holds the near-zero limit on squared range at address 0;
// write it only while the pipeline is empty (the block does not enforce this).
// The pipeline depth is set by the square root (one root bit per stage, 32
// stages) and by the six quotient units (one quotient bit per stage, 32 stages),
// plus the multiplier stages around them. Throughput is one transaction per
// cycle while the receiver does not stall.
// Reset clears all stage valid bits and loads the limit with its reset value 7.
// When the receiver stalls, the whole pipeline holds and in_tready falls, so no
// transaction is lost or repeated.
module radar_measurement_jacobian (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // pos_x, pos_y, vel_x, vel_y
  input  logic [4*32-1:0]           in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy
  output logic [6*32-1:0]           out_tdata,
  // degenerate
  output logic                      out_tuser,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rmj_pkg::W_ADDR-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import rmj_pkg::*;

  localparam int N_SQ = W_ITEM;
  localparam int N_DV = W_ITEM;

  logic en;
  logic [W_LIM-1:0] lim_r;

  logic                     v1_r, v2_r, v3_r, v4_r, va_r, vb_r, out_v_r;
  logic [W_ITEM-1:0]        mx1_r, my1_r, mx2_r, my2_r, mx3_r, my3_r;
  logic                     nx1_r, ny1_r, pp1_r, nx2_r, ny2_r, pp2_r, nx3_r, ny3_r, pp3_r;
  logic signed [W_SQR-1:0]  p1_r, p2_r;
  logic [W_SQR-1:0]         sqx_r, sqy_r, cmag_r, r2_3_r;
  logic                     cneg2_r, cneg3_r;
  logic [W_SQR-1:0]         pxl_r, pxh_r, pyl_r, pyh_r;
  side_t                    s4_r;
  logic [W_ITEM-1:0]        mx_in, my_in;
  logic signed [W_SQR:0]    diff;

  logic [N_SQ-1:0]          sq_v_r;
  sq_t                      sq_r   [N_SQ];
  sq_t                      sq_nxt [N_SQ];

  side_t                    sa_r, sb_r;
  logic [W_ITEM-1:0]        ra_r, rb_r;
  logic [W_SQR-1:0]         r3lo_r, r3hi_r;
  logic [W_CUBE-1:0]        r3_r;

  logic [N_DV:0]            dv_v_r;
  dv_t                      dv_r   [N_DV+1];
  dv_t                      dv_nxt [N_DV+1];

  logic [6*W_ITEM-1:0]      out_d_r;
  logic                     out_u_r;
  logic [6*W_ITEM-1:0]      out_d_nxt;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_NEAR_ZERO_LIMIT) ? {16'd0, lim_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_NEAR_ZERO_LIMIT) begin
      lim_r <= cfg_pwdata[W_LIM-1:0];
    end
  end

  assign mx_in = in_tdata[31] ? (~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
  assign my_in = in_tdata[63] ? (~in_tdata[63:32] + 32'd1) : in_tdata[63:32];
  assign diff  = {p1_r[W_SQR-1], p1_r} - {p2_r[W_SQR-1], p2_r};

  always_comb begin
    for (int k = 0; k < N_SQ; k++) begin
      sq_t                src;
      logic [W_SQREM+1:0] t;
      logic [W_SQREM+1:0] trial;
      if (k == 0) begin
        src.side = s4_r;
        src.rem  = '0;
        src.root = '0;
      end else begin
        src = sq_r[k-1];
      end
      t     = {src.rem, src.side.r2[W_SQR-1-2*k -: 2]};
      trial = {2'b00, src.root, 2'b01};
      sq_nxt[k].side = src.side;
      if (t >= trial) begin
        sq_nxt[k].rem  = W_SQREM'(t - trial);
        sq_nxt[k].root = {src.root[W_ITEM-2:0], 1'b1};
      end else begin
        sq_nxt[k].rem  = W_SQREM'(t);
        sq_nxt[k].root = {src.root[W_ITEM-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    logic [W_NUM-1:0] num [N_LANE];
    logic [W_DEN-1:0] den [N_LANE];
    logic             neg [N_LANE];
    num[0] = W_NUM'(sb_r.mx) << FRAC_BITS;
    num[1] = W_NUM'(sb_r.my) << FRAC_BITS;
    num[2] = W_NUM'(sb_r.my) << (2 * FRAC_BITS);
    num[3] = W_NUM'(sb_r.mx) << (2 * FRAC_BITS);
    num[4] = W_NUM'(sb_r.prody) << FRAC_BITS;
    num[5] = W_NUM'(sb_r.prodx) << FRAC_BITS;
    den[0] = W_DEN'(rb_r);
    den[1] = W_DEN'(rb_r);
    den[2] = W_DEN'(sb_r.r2);
    den[3] = W_DEN'(sb_r.r2);
    den[4] = r3_r;
    den[5] = r3_r;
    neg[0] = sb_r.negx;
    neg[1] = sb_r.negy;
    neg[2] = sb_r.pypos;
    neg[3] = sb_r.negx;
    neg[4] = sb_r.negy != sb_r.cneg;
    neg[5] = sb_r.negx == sb_r.cneg;
    dv_nxt[0].deg = sb_r.deg;
    for (int i = 0; i < N_LANE; i++) begin
      dv_nxt[0].ln[i].neg  = neg[i];
      dv_nxt[0].ln[i].over = W_OVC'(num[i]) >= {den[i], {W_ITEM{1'b0}}};
      dv_nxt[0].ln[i].nlo  = num[i][W_ITEM-1:0];
      dv_nxt[0].ln[i].den  = den[i];
      dv_nxt[0].ln[i].rem  = W_DEN'(num[i] >> W_ITEM);
      dv_nxt[0].ln[i].q    = '0;
    end
    for (int k = 1; k <= N_DV; k++) begin
      dv_nxt[k].deg = dv_r[k-1].deg;
      for (int i = 0; i < N_LANE; i++) begin
        lane_t           a;
        logic [W_DEN:0]  t;
        logic            b;
        a = dv_r[k-1].ln[i];
        t = {a.rem, a.nlo[W_ITEM-1]};
        b = t >= {1'b0, a.den};
        dv_nxt[k].ln[i].neg  = a.neg;
        dv_nxt[k].ln[i].over = a.over;
        dv_nxt[k].ln[i].nlo  = {a.nlo[W_ITEM-2:0], 1'b0};
        dv_nxt[k].ln[i].den  = a.den;
        dv_nxt[k].ln[i].rem  = b ? W_DEN'(t - {1'b0, a.den}) : W_DEN'(t);
        dv_nxt[k].ln[i].q    = {a.q[W_ITEM-2:0], b};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N_LANE; i++) begin
      lane_t             a;
      logic [W_ITEM-1:0] cap;
      logic [W_ITEM-1:0] q;
      a   = dv_r[N_DV].ln[i];
      cap = a.neg ? CAP_NEG : CAP_POS;
      q   = (a.over || a.q > cap) ? cap : a.q;
      if (dv_r[N_DV].deg) begin
        out_d_nxt[i*W_ITEM +: W_ITEM] = '0;
      end else begin
        out_d_nxt[i*W_ITEM +: W_ITEM] = a.neg ? (~q + 32'd1) : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      sq_v_r  <= '0;
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      sq_v_r  <= {sq_v_r[N_SQ-2:0], v4_r};
      va_r    <= sq_v_r[N_SQ-1];
      vb_r    <= va_r;
      dv_v_r  <= {dv_v_r[N_DV-1:0], vb_r};
      out_v_r <= dv_v_r[N_DV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1_r <= mx_in;
      my1_r <= my_in;
      nx1_r <= in_tdata[31];
      ny1_r <= in_tdata[63];
      pp1_r <= !in_tdata[63] && (in_tdata[63:32] != 32'd0);
      p1_r  <= $signed(in_tdata[95:64]) * $signed(in_tdata[63:32]);
      p2_r  <= $signed(in_tdata[127:96]) * $signed(in_tdata[31:0]);

      mx2_r   <= mx1_r;
      my2_r   <= my1_r;
      nx2_r   <= nx1_r;
      ny2_r   <= ny1_r;
      pp2_r   <= pp1_r;
      sqx_r   <= mx1_r * mx1_r;
      sqy_r   <= my1_r * my1_r;
      cneg2_r <= diff[W_SQR];
      cmag_r  <= diff[W_SQR] ? W_SQR'(-diff) : W_SQR'(diff);

      mx3_r   <= mx2_r;
      my3_r   <= my2_r;
      nx3_r   <= nx2_r;
      ny3_r   <= ny2_r;
      pp3_r   <= pp2_r;
      cneg3_r <= cneg2_r;
      r2_3_r  <= sqx_r + sqy_r;
      pxl_r   <= mx2_r * cmag_r[31:0];
      pxh_r   <= mx2_r * cmag_r[63:32];
      pyl_r   <= my2_r * cmag_r[31:0];
      pyh_r   <= my2_r * cmag_r[63:32];

      s4_r.mx    <= mx3_r;
      s4_r.my    <= my3_r;
      s4_r.negx  <= nx3_r;
      s4_r.negy  <= ny3_r;
      s4_r.pypos <= pp3_r;
      s4_r.cneg  <= cneg3_r;
      s4_r.r2    <= r2_3_r;
      s4_r.prodx <= W_CUBE'(pxl_r) + {pxh_r, {W_ITEM{1'b0}}};
      s4_r.prody <= W_CUBE'(pyl_r) + {pyh_r, {W_ITEM{1'b0}}};
      s4_r.deg   <= (r2_3_r == '0) ||
                    (r2_3_r < (W_SQR'(lim_r) << FRAC_BITS));

      for (int k = 0; k < N_SQ; k++) begin
        sq_r[k] <= sq_nxt[k];
      end

      sa_r   <= sq_r[N_SQ-1].side;
      ra_r   <= sq_r[N_SQ-1].root;
      r3lo_r <= sq_r[N_SQ-1].side.r2[31:0] * sq_r[N_SQ-1].root;
      r3hi_r <= sq_r[N_SQ-1].side.r2[63:32] * sq_r[N_SQ-1].root;

      sb_r <= sa_r;
      rb_r <= ra_r;
      r3_r <= W_CUBE'(r3lo_r) + {r3hi_r, {W_ITEM{1'b0}}};

      for (int k = 0; k <= N_DV; k++) begin
        dv_r[k] <= dv_nxt[k];
      end

      out_d_r <= out_d_nxt;
      out_u_r <= dv_r[N_DV].deg;
    end
  end

endmodule
